### rtl/svt_pkg.sv
// shared types and constants of the sparse vector table
`default_nettype none

package svt_pkg;

	localparam int DATA_W     = 32;
	localparam int VLEN_W     = 17;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [VLEN_W-1:0] VLEN_RESET = 17'd65536;

	localparam logic REG_VECTOR_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		CMD_SET = 2'd0,
		CMD_GET = 2'd1,
		CMD_ADD = 2'd2,
		CMD_SUB = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_SEARCH  = 3'd1,
		MODE_SHIFT_R = 3'd2,
		MODE_SHIFT_L = 3'd3,
		MODE_DONE    = 3'd4
	} mode_t;

	typedef struct packed {
		mode_t   mode;
		cmd_t    cmd;
		status_t status;
		logic    ins;
		logic    rem;
	} tok_ctl_t;

endpackage

`default_nettype wire

### rtl/svt_if.sv
// request and response channel interfaces
`default_nettype none

interface svt_req_if #(
	parameter int INDEX_BITS = 16
) ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [INDEX_BITS-1:0] elem_index;
	logic signed [31:0]    elem_value;

	modport source (output valid, command, elem_index, elem_value, input ready);
	modport sink   (input valid, command, elem_index, elem_value, output ready);
endinterface

interface svt_rsp_if #(
	parameter int CNT_W = 9
) ();
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic [CNT_W-1:0]   nonzero_count;

	modport source (output valid, read_value, status, nonzero_count, input ready);
	modport sink   (input valid, read_value, status, nonzero_count, output ready);
endinterface

`default_nettype wire

### rtl/svt_cfg_regs.sv
// apb register file holding the vector length
`default_nettype none

module svt_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [svt_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [svt_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [svt_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	output logic      [svt_pkg::VLEN_W-1:0]        vector_length
);

	logic                         reg_sel;
	logic                         wr_en;
	logic [svt_pkg::VLEN_W-1:0]   vlen_q;

	assign reg_sel = paddr[svt_pkg::APB_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= svt_pkg::VLEN_RESET;
		end else if (wr_en && (reg_sel == svt_pkg::REG_VECTOR_LENGTH)) begin
			vlen_q <= pwdata[svt_pkg::VLEN_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_sel)
			svt_pkg::REG_VECTOR_LENGTH: begin
				prdata = {{(svt_pkg::APB_DATA_W - svt_pkg::VLEN_W){1'b0}}, vlen_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign vector_length = vlen_q;

endmodule

`default_nettype wire

### rtl/svt_cell.sv
// one table cell: an entry plus the command token passing through it
`default_nettype none

module svt_cell #(
	parameter int CELL_ID    = 0,
	parameter int INDEX_BITS = 16,
	parameter int CNT_W      = 9
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [CNT_W-1:0]              count,
	input  wire logic                          full,
	input  wire svt_pkg::tok_ctl_t             tok_in_ctl,
	input  wire logic [INDEX_BITS-1:0]         tok_in_idx,
	input  wire logic [svt_pkg::DATA_W-1:0]    tok_in_val,
	input  wire logic [svt_pkg::DATA_W-1:0]    tok_in_res,
	input  wire logic [INDEX_BITS-1:0]         nbr_idx,
	input  wire logic [svt_pkg::DATA_W-1:0]    nbr_val,
	output svt_pkg::tok_ctl_t                  tok_out_ctl,
	output logic      [INDEX_BITS-1:0]         tok_out_idx,
	output logic      [svt_pkg::DATA_W-1:0]    tok_out_val,
	output logic      [svt_pkg::DATA_W-1:0]    tok_out_res,
	output logic      [INDEX_BITS-1:0]         entry_idx,
	output logic      [svt_pkg::DATA_W-1:0]    entry_val
);

	localparam logic [CNT_W-1:0] ID = CNT_W'(CELL_ID);

	logic [INDEX_BITS-1:0]       e_idx_q;
	logic [svt_pkg::DATA_W-1:0]  e_val_q;
	svt_pkg::tok_ctl_t           tok_ctl_q;
	logic [INDEX_BITS-1:0]       tok_idx_q;
	logic [svt_pkg::DATA_W-1:0]  tok_val_q;
	logic [svt_pkg::DATA_W-1:0]  tok_res_q;

	logic                        live;
	logic                        lt;
	logic                        eq;
	logic [svt_pkg::DATA_W-1:0]  old_val;
	logic [svt_pkg::DATA_W-1:0]  new_val;

	svt_pkg::tok_ctl_t           ctl_n;
	logic [INDEX_BITS-1:0]       idx_n;
	logic [svt_pkg::DATA_W-1:0]  val_n;
	logic [svt_pkg::DATA_W-1:0]  res_n;
	logic                        wr;
	logic [INDEX_BITS-1:0]       w_idx;
	logic [svt_pkg::DATA_W-1:0]  w_val;

	assign live    = ID < count;
	assign lt      = live && (e_idx_q < tok_in_idx);
	assign eq      = live && (e_idx_q == tok_in_idx);
	assign old_val = eq ? e_val_q : '0;

	always_comb begin
		case (tok_in_ctl.cmd)
			svt_pkg::CMD_SET: new_val = tok_in_val;
			svt_pkg::CMD_GET: new_val = old_val;
			svt_pkg::CMD_ADD: new_val = old_val + tok_in_val;
			default:          new_val = old_val - tok_in_val;
		endcase
	end

	always_comb begin
		ctl_n = tok_in_ctl;
		idx_n = tok_in_idx;
		val_n = tok_in_val;
		res_n = tok_in_res;
		wr    = 1'b0;
		w_idx = e_idx_q;
		w_val = e_val_q;
		unique case (tok_in_ctl.mode)
			svt_pkg::MODE_SEARCH: begin
				if (!lt) begin
					ctl_n.mode = svt_pkg::MODE_DONE;
					if (tok_in_ctl.cmd == svt_pkg::CMD_GET) begin
						res_n = old_val;
					end else if (new_val == '0) begin
						res_n = '0;
						if (eq) begin
							// remove: pull the rest of the table one place left
							wr         = 1'b1;
							w_idx      = nbr_idx;
							w_val      = nbr_val;
							ctl_n.rem  = 1'b1;
							ctl_n.mode = svt_pkg::MODE_SHIFT_L;
						end
					end else if (eq) begin
						wr    = 1'b1;
						w_val = new_val;
						res_n = new_val;
					end else if (full) begin
						ctl_n.status = svt_pkg::ST_FULL;
						res_n        = '0;
					end else begin
						// insert: the displaced entry rides on to the right
						wr         = 1'b1;
						w_idx      = tok_in_idx;
						w_val      = new_val;
						idx_n      = e_idx_q;
						val_n      = e_val_q;
						res_n      = new_val;
						ctl_n.ins  = 1'b1;
						ctl_n.mode = svt_pkg::MODE_SHIFT_R;
					end
				end
			end
			svt_pkg::MODE_SHIFT_R: begin
				wr    = 1'b1;
				w_idx = tok_in_idx;
				w_val = tok_in_val;
				idx_n = e_idx_q;
				val_n = e_val_q;
			end
			svt_pkg::MODE_SHIFT_L: begin
				wr    = 1'b1;
				w_idx = nbr_idx;
				w_val = nbr_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			e_idx_q <= w_idx;
			e_val_q <= w_val;
		end
		tok_idx_q <= idx_n;
		tok_val_q <= val_n;
		tok_res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ctl_q <= '{mode: svt_pkg::MODE_IDLE, cmd: svt_pkg::CMD_SET,
				status: svt_pkg::ST_OK, ins: 1'b0, rem: 1'b0};
		end else begin
			tok_ctl_q <= ctl_n;
		end
	end

	assign tok_out_ctl = tok_ctl_q;
	assign tok_out_idx = tok_idx_q;
	assign tok_out_val = tok_val_q;
	assign tok_out_res = tok_res_q;
	assign entry_idx   = e_idx_q;
	assign entry_val   = e_val_q;

endmodule

`default_nettype wire

### rtl/sparse_vector_table_core.sv
// top level of the sparse vector table
// A command is accepted when req.ready is high; the block then works on that one command until
// its result has moved to the output register. An in-range command walks a chain of MAX_NNZ
// cells, one cell per cycle, each cell holding one (index, value) entry in ascending index order;
// its result then passes from the last cell to the pending and output registers. Out-of-range
// commands go straight to the pending register. Entries move by one cell per cycle as the command
// passes, so insert and remove need no extra time. The output register lets a new command be
// accepted while the previous result still waits to be taken. No clearing pass after reset.
`default_nettype none

module sparse_vector_table_core #(
	parameter int MAX_NNZ    = 256,
	parameter int INDEX_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [svt_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [svt_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [svt_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	svt_req_if.sink                                req,
	svt_rsp_if.source                              rsp
);

	localparam int CNT_W = $clog2(MAX_NNZ + 1);
	localparam int CMP_W = ((INDEX_BITS > svt_pkg::VLEN_W) ? INDEX_BITS : svt_pkg::VLEN_W) + 1;

	logic [svt_pkg::VLEN_W-1:0]  vector_length;

	svt_pkg::tok_ctl_t           tok_ctl [0:MAX_NNZ];
	logic [INDEX_BITS-1:0]       tok_idx [0:MAX_NNZ];
	logic [svt_pkg::DATA_W-1:0]  tok_val [0:MAX_NNZ];
	logic [svt_pkg::DATA_W-1:0]  tok_res [0:MAX_NNZ];
	logic [INDEX_BITS-1:0]       ent_idx [0:MAX_NNZ];
	logic [svt_pkg::DATA_W-1:0]  ent_val [0:MAX_NNZ];

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        full;
	logic                        accept;
	logic                        in_range;

	logic                        pend_valid_q;
	logic [svt_pkg::DATA_W-1:0]  pend_res_q;
	svt_pkg::status_t            pend_st_q;
	logic [CNT_W-1:0]            pend_cnt_q;

	logic                        out_valid_q;
	logic [svt_pkg::DATA_W-1:0]  out_res_q;
	svt_pkg::status_t            out_st_q;
	logic [CNT_W-1:0]            out_cnt_q;

	logic                        exit_valid;
	logic [svt_pkg::DATA_W-1:0]  exit_res;
	svt_pkg::status_t            exit_st;
	logic [CNT_W-1:0]            cnt_n;
	logic                        move;

	svt_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.vector_length (vector_length)
	);

	assign req.ready = !busy_q;
	assign accept    = req.valid && req.ready;
	assign in_range  = CMP_W'(req.elem_index) < CMP_W'(vector_length);
	assign full      = cnt_q == CNT_W'(MAX_NNZ);

	always_comb begin
		tok_ctl[0].mode   = (accept && in_range) ? svt_pkg::MODE_SEARCH : svt_pkg::MODE_IDLE;
		tok_ctl[0].cmd    = svt_pkg::cmd_t'(req.command);
		tok_ctl[0].status = svt_pkg::ST_OK;
		tok_ctl[0].ins    = 1'b0;
		tok_ctl[0].rem    = 1'b0;
	end
	assign tok_idx[0] = req.elem_index;
	assign tok_val[0] = req.elem_value;
	assign tok_res[0] = '0;

	assign ent_idx[MAX_NNZ] = '0;
	assign ent_val[MAX_NNZ] = '0;

	for (genvar i = 0; i < MAX_NNZ; i++) begin : g_cell
		svt_cell #(
			.CELL_ID    (i),
			.INDEX_BITS (INDEX_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.count       (cnt_q),
			.full        (full),
			.tok_in_ctl  (tok_ctl[i]),
			.tok_in_idx  (tok_idx[i]),
			.tok_in_val  (tok_val[i]),
			.tok_in_res  (tok_res[i]),
			.nbr_idx     (ent_idx[i+1]),
			.nbr_val     (ent_val[i+1]),
			.tok_out_ctl (tok_ctl[i+1]),
			.tok_out_idx (tok_idx[i+1]),
			.tok_out_val (tok_val[i+1]),
			.tok_out_res (tok_res[i+1]),
			.entry_idx   (ent_idx[i]),
			.entry_val   (ent_val[i])
		);
	end

	// a token still searching at the far end passed a full table of smaller indices
	always_comb begin
		exit_valid = tok_ctl[MAX_NNZ].mode != svt_pkg::MODE_IDLE;
		exit_res   = tok_res[MAX_NNZ];
		exit_st    = tok_ctl[MAX_NNZ].status;
		cnt_n      = cnt_q;
		if (tok_ctl[MAX_NNZ].mode == svt_pkg::MODE_SEARCH) begin
			exit_res = '0;
			if ((tok_ctl[MAX_NNZ].cmd != svt_pkg::CMD_GET) && (tok_val[MAX_NNZ] != '0)) begin
				exit_st = svt_pkg::ST_FULL;
			end else begin
				exit_st = svt_pkg::ST_OK;
			end
		end else if (tok_ctl[MAX_NNZ].ins) begin
			cnt_n = cnt_q + CNT_W'(1);
		end else if (tok_ctl[MAX_NNZ].rem) begin
			cnt_n = cnt_q - CNT_W'(1);
		end
	end

	assign move = pend_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (exit_valid) begin
				cnt_q <= cnt_n;
			end
			if ((accept && !in_range) || exit_valid) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_range) begin
			pend_res_q <= '0;
			pend_st_q  <= svt_pkg::ST_RANGE;
			pend_cnt_q <= cnt_q;
		end else if (exit_valid) begin
			pend_res_q <= exit_res;
			pend_st_q  <= exit_st;
			pend_cnt_q <= cnt_n;
		end
		if (move) begin
			out_res_q <= pend_res_q;
			out_st_q  <= pend_st_q;
			out_cnt_q <= pend_cnt_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_value    = out_res_q;
	assign rsp.status        = out_st_q;
	assign rsp.nonzero_count = out_cnt_q;

endmodule

`default_nettype wire

### rtl/svt_checker.sv
// port-level assertions for the sparse vector table, bound to the top level
`default_nettype none

module svt_checker #(
	parameter int MAX_NNZ = 256,
	parameter int CNT_W   = 9
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic [31:0]      rsp_read_value,
	input wire logic [1:0]       rsp_status,
	input wire logic [CNT_W-1:0] rsp_nonzero_count
);

	a_one_cmd_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second command accepted while one is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == svt_pkg::ST_OK) || (rsp_status == svt_pkg::ST_RANGE) ||
			(rsp_status == svt_pkg::ST_FULL))
		else $error("undefined status code");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_nonzero_count <= CNT_W'(MAX_NNZ))
		else $error("nonzero count above table size");

	a_error_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != svt_pkg::ST_OK) |-> rsp_read_value == '0)
		else $error("failed command returned a nonzero value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) &&
			$stable(rsp_status) && $stable(rsp_nonzero_count))
		else $error("stalled response beat changed");

endmodule

bind sparse_vector_table_core svt_checker #(
	.MAX_NNZ (MAX_NNZ),
	.CNT_W   ($clog2(MAX_NNZ + 1))
) u_svt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_read_value    (rsp.read_value),
	.rsp_status        (rsp.status),
	.rsp_nonzero_count (rsp.nonzero_count)
);

`default_nettype wire
